FILE: hw/rtl/skv_pkg.sv
// ----------------------------------------------------------------------------
// skv_pkg
// Shared constants and types of the sorted key/value table.
// ----------------------------------------------------------------------------
`default_nettype none

package skv_pkg;

  localparam int Capacity        = 16;
  localparam int KeyBits         = 32;
  localparam int ValueBits       = 32;
  localparam int EntryValueBits  = 32;
  localparam int CountBits       = $clog2(Capacity + 1);
  localparam int PosBits         = 4;
  localparam int LimitBits       = 5;
  localparam int EntryLimitReset = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_ABSENT    = 2'd3
  } status_e;

  typedef struct packed {
    logic ins_en;
    logic rem_en;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/skv_in_if.sv
// ----------------------------------------------------------------------------
// skv_in_if
// Request channel: operation, key and value word, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface skv_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         op;
  logic signed [skv_pkg::KeyBits-1:0] search_key;
  logic [skv_pkg::EntryValueBits-1:0] entry_value;

  modport source (output valid, output op, output search_key, output entry_value,
                  input ready);
  modport sink (input valid, input op, input search_key, input entry_value,
                output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/skv_out_if.sv
// ----------------------------------------------------------------------------
// skv_out_if
// Response channel: status, position and entry count, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface skv_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [skv_pkg::PosBits-1:0]   position;
  logic [skv_pkg::CountBits-1:0] count_after;

  modport source (output valid, output status, output position, output count_after,
                  input ready);
  modport sink (input valid, input status, input position, input count_after,
                output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/skv_cell.sv
// ----------------------------------------------------------------------------
// skv_cell
// One slot of the table: holds a key and value, compares against the search
// key and takes the new entry or a neighbour's entry on insert and remove.
// ----------------------------------------------------------------------------
`default_nettype none

module skv_cell (
  input  wire                                 clk_i,
  input  wire skv_pkg::cell_ctrl_t            ctrl_i,
  input  wire                                 valid_i,
  input  wire logic signed [skv_pkg::KeyBits-1:0] search_key_i,
  input  wire logic [skv_pkg::ValueBits-1:0]  new_value_i,
  input  wire                                 left_lt_i,
  input  wire logic signed [skv_pkg::KeyBits-1:0] left_key_i,
  input  wire logic [skv_pkg::ValueBits-1:0]  left_value_i,
  input  wire logic signed [skv_pkg::KeyBits-1:0] right_key_i,
  input  wire logic [skv_pkg::ValueBits-1:0]  right_value_i,
  output logic signed [skv_pkg::KeyBits-1:0]  key_o,
  output logic [skv_pkg::ValueBits-1:0]       value_o,
  output logic                                lt_o,
  output logic                                eq_o
);

  logic signed [skv_pkg::KeyBits-1:0] key_d, key_q;
  logic [skv_pkg::ValueBits-1:0]      value_d, value_q;

  assign lt_o = valid_i && (key_q < search_key_i);
  assign eq_o = valid_i && (key_q == search_key_i);

  always_comb begin
    key_d   = key_q;
    value_d = value_q;
    if (ctrl_i.ins_en && !lt_o) begin
      if (left_lt_i) begin
        key_d   = search_key_i;
        value_d = new_value_i;
      end else begin
        key_d   = left_key_i;
        value_d = left_value_i;
      end
    end else if (ctrl_i.rem_en && !lt_o) begin
      key_d   = right_key_i;
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  assign key_o   = key_q;
  assign value_o = value_q;

endmodule

`default_nettype wire

FILE: hw/rtl/sorted_key_value_table_top.sv
// ----------------------------------------------------------------------------
// sorted_key_value_table_top
// Sorted key/value table built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Requests arrive on in_i (op, search_key, entry_value) and one response per
// request leaves on out_o (status, position, count_after), both valid/ready.
// All cells compare their key against the request key in the same cycle; an
// insert moves every larger entry one cell up, a remove moves them one cell
// down, so the table is updated at the accepting clock edge.
// The response is registered and valid in the cycle after acceptance.
// Throughput: one request per cycle unless out_o stalls; the next request sees the updated table.
// in_i.ready is low only while a response is held and out_o.ready is low, so
// a stalled receiver holds the response and stops further requests.
// entry_limit is written through cfg_we_i/cfg_wdata_i; the user must do so
// only while idle, which the block does not enforce. Values above the cell
// count act as the cell count. Reset empties the table (count zero), sets the
// limit to 16 and drops any pending response; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_value_table_top (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire logic [skv_pkg::LimitBits-1:0]   cfg_wdata_i,
  skv_in_if.sink                               in_i,
  skv_out_if.source                            out_o
);

  localparam int N = skv_pkg::Capacity;

  logic [skv_pkg::LimitBits-1:0] limit_q;
  logic [skv_pkg::CountBits-1:0] count_d, count_q;
  logic [skv_pkg::CountBits-1:0] eff_limit;

  logic                          out_vld_q;
  logic [1:0]                    status_d, status_q;
  logic [skv_pkg::PosBits-1:0]   pos_d, pos_q;

  logic                          accept;
  logic                          found;
  logic [skv_pkg::PosBits-1:0]   lb_pos;
  skv_pkg::cell_ctrl_t           ctrl;

  logic [N-1:0]                         lt_vec, eq_vec, valid_vec;
  logic signed [skv_pkg::KeyBits-1:0]   key_arr [N];
  logic [skv_pkg::ValueBits-1:0]        val_arr [N];
  logic [skv_pkg::ValueBits-1:0]        new_value;

  assign accept    = in_i.valid && in_i.ready;
  assign in_i.ready = !out_vld_q || out_o.ready;
  assign new_value = in_i.entry_value[skv_pkg::ValueBits-1:0];

  assign eff_limit = (limit_q > skv_pkg::LimitBits'(N)) ? skv_pkg::CountBits'(N)
                                                         : skv_pkg::CountBits'(limit_q);

  assign found  = |eq_vec;
  assign lb_pos = skv_pkg::PosBits'($countones(lt_vec));

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      logic                               left_lt;
      logic signed [skv_pkg::KeyBits-1:0] left_key, right_key;
      logic [skv_pkg::ValueBits-1:0]      left_val, right_val;

      assign valid_vec[g] = (skv_pkg::CountBits'(g) < count_q);

      if (g == 0) begin : g_first
        assign left_lt  = 1'b1;
        assign left_key = key_arr[g];
        assign left_val = val_arr[g];
      end else begin : g_mid
        assign left_lt  = lt_vec[g-1];
        assign left_key = key_arr[g-1];
        assign left_val = val_arr[g-1];
      end

      if (g == N - 1) begin : g_last
        assign right_key = key_arr[g];
        assign right_val = val_arr[g];
      end else begin : g_inner
        assign right_key = key_arr[g+1];
        assign right_val = val_arr[g+1];
      end

      skv_cell u_cell (
        .clk_i         (clk_i),
        .ctrl_i        (ctrl),
        .valid_i       (valid_vec[g]),
        .search_key_i  (in_i.search_key),
        .new_value_i   (new_value),
        .left_lt_i     (left_lt),
        .left_key_i    (left_key),
        .left_value_i  (left_val),
        .right_key_i   (right_key),
        .right_value_i (right_val),
        .key_o         (key_arr[g]),
        .value_o       (val_arr[g]),
        .lt_o          (lt_vec[g]),
        .eq_o          (eq_vec[g])
      );
    end
  endgenerate

  always_comb begin
    ctrl     = '0;
    count_d  = count_q;
    status_d = skv_pkg::ST_DONE;
    pos_d    = '0;
    case (skv_pkg::op_e'(in_i.op))
      skv_pkg::OP_INSERT: begin
        if (count_q >= eff_limit) begin
          status_d = skv_pkg::ST_FULL;
        end else if (found) begin
          status_d = skv_pkg::ST_DUPLICATE;
        end else begin
          ctrl.ins_en = accept;
          count_d     = count_q + 1'b1;
          pos_d       = lb_pos;
        end
      end
      skv_pkg::OP_REMOVE: begin
        if (found) begin
          ctrl.rem_en = accept;
          count_d     = count_q - 1'b1;
          pos_d       = lb_pos;
        end else begin
          status_d = skv_pkg::ST_ABSENT;
        end
      end
      skv_pkg::OP_FIND: begin
        if (found) begin
          pos_d = lb_pos;
        end else begin
          status_d = skv_pkg::ST_ABSENT;
        end
      end
      default: begin
        status_d = skv_pkg::ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= skv_pkg::LimitBits'(skv_pkg::EntryLimitReset);
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (accept) begin
        count_q   <= count_d;
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      pos_q    <= pos_d;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.status      = status_q;
  assign out_o.position    = pos_q;
  assign out_o.count_after = count_q;

`ifndef SYNTHESIS
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= skv_pkg::CountBits'(N))
    else $error("entry count beyond capacity");

  a_shift_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.ins_en && ctrl.rem_en))
    else $error("insert and remove shift in the same cycle");

  a_sorted_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((lt_vec >> 1) & ~lt_vec) == '0)
    else $error("smaller keys do not form a prefix");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins_en |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow the table");
`endif

endmodule

`default_nettype wire

FILE: bench/tb_sorted_key_value_table_top.sv
// ----------------------------------------------------------------------------
// tb_sorted_key_value_table_top
// Self-checking bench for the sorted key/value table.
// ----------------------------------------------------------------------------
// A queue of table operations feeds a clocked driver. Each beat accepted on
// the request channel runs through a local model of the sorted table, which
// yields the status, slot and entry count to expect. A clocked monitor takes
// response beats and compares them field by field with those expectations.
// The entry limit is rewritten between phases, including zero, values above
// the cell count and values below the current count. Both channels idle in
// random bursts; one long receiver stall backs the block up to its input.
// ----------------------------------------------------------------------------

module tb_sorted_key_value_table_top;
  timeunit 1ns;
  timeprecision 1ps;

  import skv_pkg::*;

  localparam int LongHold = 120;

  typedef struct packed {
    op_e                        op;
    logic signed [KeyBits-1:0]  key;
    logic [EntryValueBits-1:0]  value;
  } table_op_t;

  typedef struct packed {
    status_e              status;
    logic [PosBits-1:0]   position;
    logic [CountBits-1:0] count_after;
  } table_outcome_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [LimitBits-1:0] cfg_wdata_i;

  skv_in_if  req_if ();
  skv_out_if rsp_if ();

  sorted_key_value_table_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (req_if),
    .out_o       (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // Local copy of the table
  logic signed [KeyBits-1:0] key_tbl [Capacity];
  logic [ValueBits-1:0]      val_tbl [Capacity];
  int                        tbl_count = 0;
  int                        tbl_limit = EntryLimitReset;

  table_op_t      op_backlog_q [$];
  table_outcome_t table_outcome_q [$];

  int queued_total = 0;
  int resp_count   = 0;
  int fail_cnt     = 0;
  int idle_rate    = 0;
  int limit_writes = 0;
  int op_hits [4]  = '{default: 0};
  int st_hits [4]  = '{default: 0};
  bit long_hold_go   = 1'b0;
  bit long_hold_done = 1'b0;

  logic signed [KeyBits-1:0] key_pool [24];

  function automatic table_outcome_t apply_table_op(table_op_t r);
    table_outcome_t res;
    int             lim;
    int             slot;
    bit             hit;
    res.status   = ST_DONE;
    res.position = '0;
    lim  = (tbl_limit < Capacity) ? tbl_limit : Capacity;
    slot = 0;
    while (slot < tbl_count && $signed(key_tbl[slot]) < $signed(r.key)) slot++;
    hit = (slot < tbl_count) && (key_tbl[slot] == r.key);
    case (r.op)
      OP_INSERT: begin
        if (tbl_count >= lim) begin
          res.status = ST_FULL;
        end else if (hit) begin
          res.status = ST_DUPLICATE;
        end else begin
          for (int j = tbl_count; j > slot; j--) begin
            key_tbl[j] = key_tbl[j-1];
            val_tbl[j] = val_tbl[j-1];
          end
          key_tbl[slot] = r.key;
          val_tbl[slot] = r.value[ValueBits-1:0];
          tbl_count++;
          res.position = slot[PosBits-1:0];
        end
      end
      OP_REMOVE, OP_FIND: begin
        if (hit) begin
          res.position = slot[PosBits-1:0];
          if (r.op == OP_REMOVE) begin
            for (int j = slot; j + 1 < tbl_count; j++) begin
              key_tbl[j] = key_tbl[j+1];
              val_tbl[j] = val_tbl[j+1];
            end
            tbl_count--;
          end
        end else begin
          res.status = ST_ABSENT;
        end
      end
      default: ;
    endcase
    res.count_after = tbl_count[CountBits-1:0];
    return res;
  endfunction

  // Request driver
  int        send_gap = 0;
  table_op_t nxt_op;
  table_op_t acc_op;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid       <= 1'b0;
      req_if.op          <= OP_NOP;
      req_if.search_key  <= '0;
      req_if.entry_value <= '0;
      send_gap = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        acc_op.op    = op_e'(req_if.op);
        acc_op.key   = req_if.search_key;
        acc_op.value = req_if.entry_value;
        table_outcome_q.push_back(apply_table_op(acc_op));
        op_hits[req_if.op]++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_if.valid <= 1'b0;
        end else if (op_backlog_q.size() != 0) begin
          nxt_op = op_backlog_q.pop_front();
          req_if.valid       <= 1'b1;
          req_if.op          <= nxt_op.op;
          req_if.search_key  <= nxt_op.key;
          req_if.entry_value <= nxt_op.value;
          if (idle_rate != 0 && $urandom_range(99) < idle_rate) begin
            send_gap = $urandom_range(1, 19);
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor
  int             hold_cnt = 0;
  table_outcome_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        resp_count++;
        st_hits[rsp_if.status]++;
        if (table_outcome_q.size() == 0) begin
          $error("response beat with nothing expected: status %0d position %0d count %0d",
                 rsp_if.status, rsp_if.position, rsp_if.count_after);
          fail_cnt++;
        end else begin
          want = table_outcome_q.pop_front();
          if (rsp_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_if.status);
            fail_cnt++;
          end
          if (rsp_if.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, rsp_if.position);
            fail_cnt++;
          end
          if (rsp_if.count_after !== want.count_after) begin
            $error("count_after: expected %0d, got %0d", want.count_after,
                   rsp_if.count_after);
            fail_cnt++;
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        rsp_if.ready <= 1'b0;
      end else if (long_hold_go && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_cnt = LongHold - 1;
        rsp_if.ready <= 1'b0;
      end else if (idle_rate != 0 && $urandom_range(99) < idle_rate) begin
        hold_cnt = $urandom_range(1, 19) - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  task automatic queue_op(input op_e op, input logic signed [KeyBits-1:0] key,
                          input logic [EntryValueBits-1:0] value);
    table_op_t t;
    t.op    = op;
    t.key   = key;
    t.value = value;
    op_backlog_q.push_back(t);
    queued_total++;
  endtask

  task automatic queue_random_ops(input int n, input int ins_pct);
    int                        pick;
    op_e                       op;
    logic signed [KeyBits-1:0] key;
    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7FFF_FFFF;
    key_pool[2] = 32'sh0000_0000;
    key_pool[3] = -32'sd1;
    for (int i = 4; i < 24; i++) begin
      if ($isunknown(key_pool[i]) || $urandom_range(1) == 0) key_pool[i] = $signed($urandom);
    end
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < ins_pct) op = OP_INSERT;
      else if (pick >= 95) op = OP_NOP;
      else if (pick[0]) op = OP_REMOVE;
      else op = OP_FIND;
      if ($urandom_range(19) == 0) key = $signed($urandom);
      else key = key_pool[$urandom_range(23)];
      queue_op(op, key, $urandom);
    end
  endtask

  // Hold until every response is back, then let the pipe settle
  task automatic wait_table_idle();
    while (resp_count != queued_total || op_backlog_q.size() != 0) @(negedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_entry_limit(input logic [LimitBits-1:0] lim);
    wait_table_idle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tbl_limit = lim;
    limit_writes++;
    @(negedge clk_i);
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    req_if.valid       = 1'b0;
    req_if.op          = OP_NOP;
    req_if.search_key  = '0;
    req_if.entry_value = '0;
    rsp_if.ready       = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    idle_rate = 10;
    queue_op(OP_FIND,   32'sd7, 32'h0);
    queue_op(OP_REMOVE, 32'sd7, 32'h0);
    queue_op(OP_INSERT, 32'sd0, 32'h0000_0000);
    queue_op(OP_INSERT, 32'sh8000_0000, 32'hFFFF_FFFF);
    queue_op(OP_INSERT, 32'sh7FFF_FFFF, 32'h0000_0000);
    queue_op(OP_INSERT, 32'sd0, 32'h1234_5678);
    queue_op(OP_INSERT, -32'sd1, 32'h5555_5555);
    queue_op(OP_INSERT, 32'sd1, 32'hAAAA_AAAA);
    queue_op(OP_FIND,   32'sh8000_0000, 32'h0);
    queue_op(OP_FIND,   32'sh7FFF_FFFF, 32'h0);
    queue_op(OP_FIND,   32'sd1, 32'h0);
    queue_op(OP_FIND,   32'sd2, 32'h0);
    queue_op(OP_NOP,    32'sh7FFF_FFFF, 32'hFFFF_FFFF);
    queue_op(OP_REMOVE, -32'sd1, 32'h0);
    queue_op(OP_REMOVE, 32'sh7FFF_FFFF, 32'h0);
    queue_op(OP_REMOVE, 32'sh8000_0000, 32'h0);
    queue_op(OP_REMOVE, 32'sd5, 32'h0);
    queue_op(OP_FIND,   32'sd0, 32'h0);

    // table holds two entries: full takes precedence over duplicate
    write_entry_limit(5'd2);
    queue_op(OP_INSERT, 32'sd0, 32'hDEAD_BEEF);
    queue_op(OP_INSERT, 32'sd9, 32'h0BAD_F00D);

    write_entry_limit(5'd31);
    idle_rate = 25;
    queue_random_ops(100, 70);

    // limit drops below the current count
    write_entry_limit(5'd3);
    idle_rate = 5;
    queue_random_ops(90, 35);

    write_entry_limit(5'd0);
    idle_rate = 15;
    queue_random_ops(60, 40);

    write_entry_limit(5'd16);
    idle_rate = 40;
    queue_random_ops(100, 45);

    write_entry_limit(5'd1);
    idle_rate = 10;
    queue_random_ops(60, 40);

    write_entry_limit(5'($urandom_range(4, 15)));
    idle_rate = 10;
    queue_random_ops(90, 50);
    long_hold_go = 1'b1;

    write_entry_limit(5'd16);
    idle_rate = 0;
    queue_random_ops(110, 45);

    wait_table_idle();
    repeat (5) @(posedge clk_i);
    if (table_outcome_q.size() != 0) begin
      $error("%0d expected responses never arrived", table_outcome_q.size());
      fail_cnt++;
    end
    $display("Covered %0d operations (%0d insert, %0d remove, %0d find, %0d no-op)",
             queued_total, op_hits[OP_INSERT], op_hits[OP_REMOVE], op_hits[OP_FIND],
             op_hits[OP_NOP]);
    $display("over %0d limit writes. Responses: %0d done, %0d full, %0d duplicate,",
             limit_writes, st_hits[ST_DONE], st_hits[ST_FULL], st_hits[ST_DUPLICATE]);
    $display("%0d absent; %0d mismatches.", st_hits[ST_ABSENT], fail_cnt);
    if (fail_cnt == 0) begin
      $display("** sorted_key_value_table_top: PASSED **");
    end else begin
      $display("** sorted_key_value_table_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Timed out with %0d of %0d responses received.", resp_count, queued_total);
    $display("** sorted_key_value_table_top: FAILED **");
    $finish;
  end

endmodule
